FILE: hw/rtl/positional_list_engine_top_assert.svh
// Assertion macros for the positional list engine.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("list engine assertion failed");
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine assertion failed");
`else
`define PLE_ASSERT(lbl, expr)
`define PLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/ple_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the positional list engine. No dependencies.
`default_nettype none

package ple_pkg;

  // list geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // word field widths
  localparam int OPC_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int FND_W = 6;
  localparam int LEN_W = 7;

  // width for comparing a position with the length
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // word packing
  localparam int IN_TDATA_W  = 48;
  localparam int IN_POS_LSB  = OPC_W;
  localparam int IN_VAL_LSB  = OPC_W + POS_W;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_FND_LSB = STS_W;
  localparam int OUT_RD_LSB  = STS_W + FND_W;
  localparam int OUT_LEN_LSB = STS_W + FND_W + VAL_W;
  localparam int OUT_USED_W  = STS_W + FND_W + VAL_W + LEN_W;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_VISIT  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2
  } sts_code_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_dn;
    logic scan;
    logic visit;
    logic wr_val;
    logic finish;
  } ple_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic chk_err;
    logic ins_tail;
    logic rem_tail;
    logic up_last;
    logic dn_last;
    logic scan_done;
    logic out_free;
  } ple_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_engine_top.sv
// Per word (n = length, p = position): insert shifts entries p..n-1 up and writes the value, at the
// tail only writes; remove shifts entries above p down; search reads up to n entries; visit reads one.
// One word in flight; the next word is taken the cycle after the result is registered.
// The single-port-per-direction entry RAM moves one entry per cycle during shifts and scans.
// Synchronous active-low reset empties the list; no clearing pass, entries are not reset.
`default_nettype none

`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // opcode[2:0], position[9:3], value[41:10], zero fill
  input  wire logic [ple_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], found_index[7:2], read_value[39:8], length[46:40], zero fill
  output logic      [ple_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import ple_pkg::*;

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // checks
  `PLE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `PLE_ASSERT_NEXT(a_result_after_finish, cmd.finish, out_tvalid)
  `PLE_ASSERT(a_cmd_exclusive, $onehot0(cmd))
  `PLE_ASSERT(a_length_bound, out_tvalid |-> (out_tdata[OUT_LEN_LSB +: LEN_W] <= LEN_W'(CAPACITY)))

endmodule

`default_nettype wire

FILE: hw/rtl/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ple_dp.sv
// Datapath of the positional list engine: entry RAM, length, scan/shift
// pointer, range checks and the result register. Uses ple_pkg, ple_ram.
`default_nettype none

module ple_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ple_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire ple_pkg::ple_cmd_t                  cmd,
  output ple_pkg::ple_sts_t                       sts,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [ple_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import ple_pkg::*;

  // input word fields
  logic [OPC_W-1:0]      in_opc;
  logic [POS_W-1:0]      in_pos;
  logic [DATA_WIDTH-1:0] in_val;
  op_t                   in_op;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;

  // registers
  op_t                   op_r;
  logic [CNT_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  err_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  wb_valid_r, wb_valid_nxt;
  logic [IDX_W-1:0]      wb_addr_r, wb_addr_nxt;
  logic                  cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // RAM side
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  hit_now;
  logic                  scan_more;
  logic                  scan_issue;
  logic                  chk_err;
  sts_code_t             res_sts;
  logic [VAL_W-1:0]      res_rd;

  assign in_opc = in_tdata[OPC_W-1:0];
  assign in_pos = in_tdata[IN_POS_LSB +: POS_W];
  assign in_val = in_tdata[IN_VAL_LSB +: DATA_WIDTH];
  assign in_op  = op_t'(in_opc);
  assign pos_x  = CMP_W'(in_pos);
  assign cnt_x  = CMP_W'(count_r);

  // range checks on the incoming word
  always_comb begin
    case (in_op)
      OP_INSERT: chk_err = (count_r >= CNT_W'(CAPACITY)) || (pos_x > cnt_x);
      OP_REMOVE: chk_err = (pos_x >= cnt_x);
      OP_VISIT:  chk_err = (pos_x >= cnt_x);
      OP_SEARCH: chk_err = 1'b0;
      OP_CLEAR:  chk_err = 1'b0;
      default:   chk_err = 1'b1;
    endcase
  end

  // search compare on the previous read
  assign hit_now    = cmp_valid_r && (rd_data == val_r);
  assign scan_more  = (ptr_r < count_r);
  assign scan_issue = cmd.scan && scan_more && !hit_now;

  // status to the controller
  assign sts.op        = in_op;
  assign sts.chk_err   = chk_err;
  assign sts.ins_tail  = (pos_x == cnt_x);
  assign sts.rem_tail  = ((pos_x + CMP_W'(1)) == cnt_x);
  assign sts.up_last   = (ptr_r == pos_r);
  assign sts.dn_last   = ((ptr_r + CNT_W'(1)) == count_r);
  assign sts.scan_done = hit_now || (!cmp_valid_r && !scan_more);
  assign sts.out_free  = !out_valid_r || out_tready;

  // RAM access: value write, else pending shift write-back
  assign ram_re    = cmd.shift_up || cmd.shift_dn || cmd.visit || scan_issue;
  assign ram_we    = cmd.wr_val || wb_valid_r;
  assign ram_waddr = cmd.wr_val ? pos_r[IDX_W-1:0] : wb_addr_r;
  assign ram_wdata = cmd.wr_val ? val_r : rd_data;

  ple_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ptr_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  // pointer and pipeline tracking
  always_comb begin
    ptr_nxt       = ptr_r;
    wb_valid_nxt  = cmd.shift_up || cmd.shift_dn;
    wb_addr_nxt   = cmd.shift_up ? (ptr_r[IDX_W-1:0] + IDX_W'(1))
                                 : (ptr_r[IDX_W-1:0] - IDX_W'(1));
    cmp_valid_nxt = scan_issue;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    if (cmd.load) begin
      hit_nxt   = 1'b0;
      found_nxt = '0;
      case (in_op)
        OP_INSERT: ptr_nxt = count_r - CNT_W'(1);
        OP_REMOVE: ptr_nxt = CNT_W'(in_pos) + CNT_W'(1);
        OP_VISIT:  ptr_nxt = CNT_W'(in_pos);
        default:   ptr_nxt = '0;
      endcase
    end else if (cmd.shift_up) begin
      ptr_nxt = ptr_r - CNT_W'(1);
    end else if (cmd.shift_dn || scan_issue) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    if (cmd.scan && hit_now) begin
      hit_nxt   = 1'b1;
      found_nxt = cmp_idx_r;
    end
  end

  // length after this operation
  always_comb begin
    count_nxt = count_r;
    if (!err_r) begin
      case (op_r)
        OP_INSERT: count_nxt = count_r + CNT_W'(1);
        OP_REMOVE: count_nxt = count_r - CNT_W'(1);
        OP_CLEAR:  count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
  end

  // result word
  always_comb begin
    if (err_r) begin
      res_sts = ST_RANGE;
    end else if ((op_r == OP_SEARCH) && !hit_r) begin
      res_sts = ST_MISSING;
    end else begin
      res_sts = ST_OK;
    end
    res_rd = ((op_r == OP_VISIT) && !err_r) ? VAL_W'(rd_data) : '0;
    out_data_nxt = out_data_r;
    if (cmd.finish) begin
      out_data_nxt = OUT_TDATA_W'({LEN_W'(count_nxt), res_rd, FND_W'(found_r), res_sts});
    end
    out_valid_nxt = cmd.finish ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wb_valid_r  <= 1'b0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
      wb_valid_r  <= wb_valid_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= CNT_W'(in_pos);
      val_r <= in_val;
      err_r <= chk_err;
    end
    ptr_r      <= ptr_nxt;
    wb_addr_r  <= wb_addr_nxt;
    cmp_idx_r  <= ptr_r[IDX_W-1:0];
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ple_ctrl.sv
// Controller of the positional list engine: sequences shifts, scans,
// reads and result hand-off. Uses ple_pkg.
`default_nettype none

module ple_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ple_pkg::ple_sts_t sts,
  output ple_pkg::ple_cmd_t      cmd
);

  import ple_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SHUP     = 8'b0000_0010,
    S_UP_DRAIN = 8'b0000_0100,
    S_WRITE    = 8'b0000_1000,
    S_SHDN     = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_VISIT    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.chk_err) begin
            state_nxt = S_DONE;
          end else begin
            case (sts.op)
              OP_INSERT: state_nxt = sts.ins_tail ? S_WRITE : S_SHUP;
              OP_REMOVE: state_nxt = sts.rem_tail ? S_DONE : S_SHDN;
              OP_SEARCH: state_nxt = S_SCAN;
              OP_VISIT:  state_nxt = S_VISIT;
              default:   state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_SHUP: begin
        cmd.shift_up = 1'b1;
        if (sts.up_last) begin
          state_nxt = S_UP_DRAIN;
        end
      end
      // last write-back takes the write port
      S_UP_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SHDN: begin
        cmd.shift_dn = 1'b1;
        if (sts.dn_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_VISIT: begin
        cmd.visit = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
